// File: hw/rtl/fsba_pkg.sv
// ----------------------------------------------------------------------------
// fsba_pkg
// shared constants, codes and types of the fixed slot buffer allocator
// ----------------------------------------------------------------------------
package fsba_pkg;

    localparam int unsigned MAX_SLOTS  = 1024;
    localparam int unsigned SIZE_LIMIT = 1048576;

    localparam int unsigned IDX_W    = 10;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned SIZE_W   = 21;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned OFS_W    = 30;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W    = 32;

    // operations
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DESC  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] STS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_READY   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NO_FREE     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_WRONG_STATE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_TAG = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctl_cmd;

endpackage

// File: hw/rtl/fsba_ctrl.sv
// ----------------------------------------------------------------------------
// fsba_ctrl
// request sequencer: takes one request, runs its update cycle, owns the
// output valid flag
// ----------------------------------------------------------------------------
module fsba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsba_pkg::t_ctl_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic capture, execute;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign capture     = i_in_valid && (r_state == ST_IDLE);
    assign execute     = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture = capture;
        o_cmd.execute = execute;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (capture) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (execute) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (execute) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/fsba_datapath.sv
// ----------------------------------------------------------------------------
// fsba_datapath
// configuration registers, free stack and busy memories, counters and
// result register
// ----------------------------------------------------------------------------
module fsba_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fsba_pkg::t_ctl_cmd                  i_cmd,
    input  logic [fsba_pkg::OP_W-1:0]           i_op,
    input  logic [fsba_pkg::IDX_W-1:0]          i_slot_index,
    input  logic                                i_cfg_we,
    input  logic [fsba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsba_pkg::CFG_W-1:0]          i_cfg_wdata,
    output logic [fsba_pkg::STATUS_W-1:0]       o_status,
    output logic [fsba_pkg::IDX_W-1:0]          o_granted_slot,
    output logic [fsba_pkg::OFS_W-1:0]          o_byte_offset,
    output logic [fsba_pkg::SIZE_W-1:0]         o_byte_length,
    output logic [fsba_pkg::TAG_W-1:0]          o_tag_out,
    output logic                                o_is_allocated,
    output logic [fsba_pkg::CNT_W-1:0]          o_free_slots
);

    localparam int unsigned PROD_W = fsba_pkg::IDX_W + fsba_pkg::SIZE_W;

    // memories
    logic [fsba_pkg::IDX_W-1:0] stack_mem [fsba_pkg::MAX_SLOTS];
    logic                       busy_mem  [fsba_pkg::MAX_SLOTS];

    // configuration
    logic [fsba_pkg::CNT_W-1:0]  r_slot_count;
    logic [fsba_pkg::SIZE_W-1:0] r_slot_size;
    logic [fsba_pkg::TAG_W-1:0]  r_buffer_tag;

    // pool state; r_fill marks the stack positions written since rebuild
    logic [fsba_pkg::CNT_W-1:0]  r_depth, n_depth;
    logic [fsba_pkg::CNT_W-1:0]  r_busy_cnt, n_busy_cnt;
    logic [fsba_pkg::CNT_W-1:0]  r_fill, n_fill;

    // captured request and memory read data
    logic [fsba_pkg::OP_W-1:0]   r_op;
    logic [fsba_pkg::IDX_W-1:0]  r_idx;
    logic [fsba_pkg::IDX_W-1:0]  r_stack_q;
    logic                        r_busy_q;

    // result register
    logic [fsba_pkg::STATUS_W-1:0] r_status, n_status;
    logic [fsba_pkg::IDX_W-1:0]    r_granted, n_granted;
    logic [fsba_pkg::OFS_W-1:0]    r_offset, n_offset;
    logic [fsba_pkg::SIZE_W-1:0]   r_length, n_length;
    logic [fsba_pkg::TAG_W-1:0]    r_tag, n_tag;
    logic                          r_alloc, n_alloc;
    logic [fsba_pkg::CNT_W-1:0]    r_free, n_free;

    logic                        ready;
    logic [fsba_pkg::CNT_W-1:0]  pos;
    logic [fsba_pkg::CNT_W-1:0]  pos_m1;
    logic [fsba_pkg::IDX_W-1:0]  popped;
    logic                        idx_busy;
    logic                        idx_ok;
    logic                        do_alloc;
    logic                        do_free;
    logic [PROD_W-1:0]           product;
    logic [fsba_pkg::CNT_W-1:0]  cfg_count;
    logic [fsba_pkg::SIZE_W-1:0] cfg_size;

    assign ready  = (r_slot_count != '0) && (r_slot_size != '0);
    assign pos    = r_slot_count - r_depth;
    assign pos_m1 = pos - fsba_pkg::CNT_W'(1);
    // unwritten positions hold their own index, unallocated slots read free
    assign popped   = (pos >= r_fill) ? pos[fsba_pkg::IDX_W-1:0] : r_stack_q;
    assign idx_busy = ({1'b0, r_idx} < r_fill) ? r_busy_q : 1'b0;
    assign idx_ok   = {1'b0, r_idx} < r_slot_count;
    assign product  = PROD_W'(r_idx) * PROD_W'(r_slot_size);

    assign cfg_count = (i_cfg_wdata[fsba_pkg::CNT_W-1:0] > fsba_pkg::CNT_W'(fsba_pkg::MAX_SLOTS))
                     ? fsba_pkg::CNT_W'(fsba_pkg::MAX_SLOTS)
                     : i_cfg_wdata[fsba_pkg::CNT_W-1:0];
    assign cfg_size  = (i_cfg_wdata[fsba_pkg::SIZE_W-1:0]
                        > fsba_pkg::SIZE_W'(fsba_pkg::SIZE_LIMIT))
                     ? fsba_pkg::SIZE_W'(fsba_pkg::SIZE_LIMIT)
                     : i_cfg_wdata[fsba_pkg::SIZE_W-1:0];

    always_comb begin
        n_status  = fsba_pkg::STS_OK;
        n_granted = r_idx;
        n_offset  = '0;
        n_length  = '0;
        n_tag     = '0;
        n_alloc   = 1'b0;
        do_alloc  = 1'b0;
        do_free   = 1'b0;
        if (!ready) begin
            n_status = fsba_pkg::STS_NOT_READY;
            if (r_op == fsba_pkg::OP_ALLOC) begin
                n_granted = '0;
            end
        end else begin
            case (r_op)
                fsba_pkg::OP_ALLOC: begin
                    n_granted = '0;
                    if (r_depth == '0 || {1'b0, popped} >= r_slot_count) begin
                        n_status = fsba_pkg::STS_NO_FREE;
                    end else begin
                        n_granted = popped;
                        do_alloc  = 1'b1;
                    end
                end
                fsba_pkg::OP_FREE: begin
                    if (!idx_ok) begin
                        n_status = fsba_pkg::STS_BAD_INDEX;
                    end else if (!idx_busy || r_depth >= r_slot_count || r_busy_cnt == '0) begin
                        n_status = fsba_pkg::STS_WRONG_STATE;
                    end else begin
                        do_free = 1'b1;
                    end
                end
                fsba_pkg::OP_DESC: begin
                    if (!idx_ok) begin
                        n_status = fsba_pkg::STS_BAD_INDEX;
                    end else if (!idx_busy) begin
                        n_status = fsba_pkg::STS_WRONG_STATE;
                    end else begin
                        n_offset = product[fsba_pkg::OFS_W-1:0];
                        n_length = r_slot_size;
                        n_tag    = r_buffer_tag;
                    end
                end
                fsba_pkg::OP_QUERY: begin
                    if (!idx_ok) begin
                        n_status = fsba_pkg::STS_BAD_INDEX;
                    end else begin
                        n_alloc = idx_busy;
                    end
                end
                default: begin
                    n_status = fsba_pkg::STS_NOT_READY;
                end
            endcase
        end
    end

    always_comb begin
        n_depth    = r_depth;
        n_busy_cnt = r_busy_cnt;
        n_fill     = r_fill;
        if (do_alloc) begin
            n_depth    = r_depth - fsba_pkg::CNT_W'(1);
            n_busy_cnt = r_busy_cnt + fsba_pkg::CNT_W'(1);
            if (pos >= r_fill) begin
                n_fill = pos + fsba_pkg::CNT_W'(1);
            end
        end else if (do_free) begin
            n_depth    = r_depth + fsba_pkg::CNT_W'(1);
            n_busy_cnt = r_busy_cnt - fsba_pkg::CNT_W'(1);
        end
        n_free = (ready && n_busy_cnt <= r_slot_count) ? (r_slot_count - n_busy_cnt) : '0;
    end

    // memory reads at request capture, writes in the update cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_stack_q <= stack_mem[pos[fsba_pkg::IDX_W-1:0]];
            r_busy_q  <= busy_mem[i_slot_index];
            r_op      <= i_op;
            r_idx     <= i_slot_index;
        end
        if (i_cmd.execute && do_free) begin
            stack_mem[pos_m1[fsba_pkg::IDX_W-1:0]] <= r_idx;
        end
        if (i_cmd.execute && (do_alloc || do_free)) begin
            busy_mem[do_alloc ? popped : r_idx] <= do_alloc;
        end
        if (i_cmd.execute) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_offset  <= n_offset;
            r_length  <= n_length;
            r_tag     <= n_tag;
            r_alloc   <= n_alloc;
            r_free    <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= '0;
            r_slot_size  <= fsba_pkg::SIZE_W'(1);
            r_buffer_tag <= '0;
            r_depth      <= '0;
            r_busy_cnt   <= '0;
            r_fill       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fsba_pkg::CFG_SLOT_COUNT: begin
                    r_slot_count <= cfg_count;
                    r_depth      <= cfg_count;
                    r_busy_cnt   <= '0;
                    r_fill       <= '0;
                end
                fsba_pkg::CFG_SLOT_SIZE: begin
                    r_slot_size <= cfg_size;
                end
                fsba_pkg::CFG_BUFFER_TAG: begin
                    r_buffer_tag <= i_cfg_wdata[fsba_pkg::TAG_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_cmd.execute) begin
            r_depth    <= n_depth;
            r_busy_cnt <= n_busy_cnt;
            r_fill     <= n_fill;
        end
    end

    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_byte_offset  = r_offset;
    assign o_byte_length  = r_length;
    assign o_tag_out      = r_tag;
    assign o_is_allocated = r_alloc;
    assign o_free_slots   = r_free;

endmodule

// File: hw/rtl/fixed_slot_buffer_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_buffer_allocator
// hands out equal-size buffer slots from a lifo free stack
// ----------------------------------------------------------------------------
// request channel (i_in_valid / o_in_stall): op and slot_index; one transfer
// starts one request and yields exactly one result transfer.
// result channel (o_out_valid / i_out_stall): status, granted slot,
// descriptor fields, query bit and the free slot count after the request.
// a request first reads the free stack and busy memories at capture, then
// updates them and loads the result register; no new request is taken
// until that update is done. the result register holds a finished result
// while the next request is taken; if it is still stalled when that request
// completes, the update cycle waits and the request side stays stalled.
// reset leaves slot count 0 (pool not ready), slot size 1, tag 0. the
// memories need no clearing pass: a fill mark tracks which stack positions
// and busy bits were written since the last slot count write.
// configuration writes must go in only while no request is in flight; the
// user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module fixed_slot_buffer_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [fsba_pkg::OP_W-1:0]           i_op,
    input  logic [fsba_pkg::IDX_W-1:0]          i_slot_index,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fsba_pkg::STATUS_W-1:0]       o_status,
    output logic [fsba_pkg::IDX_W-1:0]          o_granted_slot,
    output logic [fsba_pkg::OFS_W-1:0]          o_byte_offset,
    output logic [fsba_pkg::SIZE_W-1:0]         o_byte_length,
    output logic [fsba_pkg::TAG_W-1:0]          o_tag_out,
    output logic                                o_is_allocated,
    output logic [fsba_pkg::CNT_W-1:0]          o_free_slots,
    input  logic                                i_cfg_we,
    input  logic [fsba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsba_pkg::CFG_W-1:0]          i_cfg_wdata
);

    fsba_pkg::t_ctl_cmd cmd;

    fsba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fsba_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_slot_index   (i_slot_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_byte_length  (o_byte_length),
        .o_tag_out      (o_tag_out),
        .o_is_allocated (o_is_allocated),
        .o_free_slots   (o_free_slots)
    );

endmodule

// File: hw/rtl/fsba_checker.sv
// ----------------------------------------------------------------------------
// fsba_checker
// port-level checks of the fixed slot buffer allocator
// ----------------------------------------------------------------------------
module fsba_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [fsba_pkg::STATUS_W-1:0]       o_status,
    input logic [fsba_pkg::IDX_W-1:0]          o_granted_slot,
    input logic [fsba_pkg::OFS_W-1:0]          o_byte_offset,
    input logic [fsba_pkg::SIZE_W-1:0]         o_byte_length,
    input logic [fsba_pkg::TAG_W-1:0]          o_tag_out,
    input logic [fsba_pkg::CNT_W-1:0]          o_free_slots
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_granted_slot) && $stable(o_free_slots)))
        else $error("stalled result changed");

    // one request at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while another is in flight");

    // failed requests carry no descriptor
    a_fail_no_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != fsba_pkg::STS_OK) |->
            (o_byte_offset == '0 && o_byte_length == '0 && o_tag_out == '0))
        else $error("descriptor fields set on failed request");

    // pool not ready reports no free slots
    a_not_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fsba_pkg::STS_NOT_READY) |-> (o_free_slots == '0))
        else $error("free count nonzero while not ready");

endmodule

bind fixed_slot_buffer_allocator fsba_checker u_fsba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_granted_slot (o_granted_slot),
    .o_byte_offset  (o_byte_offset),
    .o_byte_length  (o_byte_length),
    .o_tag_out      (o_tag_out),
    .o_free_slots   (o_free_slots)
);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the fixed slot buffer allocator
// ----------------------------------------------------------------------------
// a directed table covers reset, not-ready pools, register saturation, empty
// stack, bad index, freeing of unheld slots and descriptors of free slots.
// random phases follow: each programs slot size and tag, most slot count too,
// then sends mostly allocate and free-of-allocated-slot requests mixed with
// descriptors, queries and noise. every result is compared with a predictor
// of the pool kept in the bench. both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 13;
    localparam int PHASE_ITEMS    = 100;

    typedef struct packed {
        logic [fsba_pkg::STATUS_W-1:0] status;
        logic [fsba_pkg::IDX_W-1:0]    granted;
        logic [fsba_pkg::OFS_W-1:0]    offset;
        logic [fsba_pkg::SIZE_W-1:0]   length;
        logic [fsba_pkg::TAG_W-1:0]    tag;
        logic                          alloc;
        logic [fsba_pkg::CNT_W-1:0]    free_cnt;
    } t_slot_result;

    typedef struct packed {
        bit                             is_cfg;
        bit                             typed;
        logic [fsba_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [fsba_pkg::CFG_W-1:0]     reg_val;
        logic [fsba_pkg::OP_W-1:0]      op;
        logic [fsba_pkg::IDX_W-1:0]     idx;
        t_slot_result                   want;
    } t_dir_row;

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_stall;
    logic [fsba_pkg::OP_W-1:0]      i_op         = '0;
    logic [fsba_pkg::IDX_W-1:0]     i_slot_index = '0;
    logic                           o_out_valid;
    logic                           i_out_stall  = 1'b0;
    logic [fsba_pkg::STATUS_W-1:0]  o_status;
    logic [fsba_pkg::IDX_W-1:0]     o_granted_slot;
    logic [fsba_pkg::OFS_W-1:0]     o_byte_offset;
    logic [fsba_pkg::SIZE_W-1:0]    o_byte_length;
    logic [fsba_pkg::TAG_W-1:0]     o_tag_out;
    logic                           o_is_allocated;
    logic [fsba_pkg::CNT_W-1:0]     o_free_slots;
    logic                           i_cfg_we     = 1'b0;
    logic [fsba_pkg::CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [fsba_pkg::CFG_W-1:0]     i_cfg_wdata  = '0;

    fixed_slot_buffer_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_byte_length  (o_byte_length),
        .o_tag_out      (o_tag_out),
        .o_is_allocated (o_is_allocated),
        .o_free_slots   (o_free_slots),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // pool copy kept by the bench
    bit          pool_busy  [fsba_pkg::MAX_SLOTS];
    int unsigned pool_stack [fsba_pkg::MAX_SLOTS];
    int unsigned pool_depth;
    int unsigned pool_held;
    int unsigned reg_count;
    int unsigned reg_size;
    int unsigned reg_tag;

    t_slot_result slot_results_due [$];
    t_slot_result seen_res;
    t_slot_result due_res;
    t_dir_row     directed [$];

    bit quiet;
    int stall_left;
    int idle_cycles;
    int mismatches;
    int requests_sent;
    int results_checked;
    int reg_writes;
    int status_seen [5];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void rebuild_pool();
        for (int i = 0; i < fsba_pkg::MAX_SLOTS; i++) begin
            pool_busy[i]  = 1'b0;
            pool_stack[i] = i;
        end
        pool_depth = reg_count;
        pool_held  = 0;
    endfunction

    function automatic void apply_reg_write(input logic [fsba_pkg::CFG_IDX_W-1:0] ri,
                                            input logic [fsba_pkg::CFG_W-1:0] v);
        int unsigned f;
        case (ri)
            fsba_pkg::CFG_SLOT_COUNT: begin
                f = 32'(v[fsba_pkg::CNT_W-1:0]);
                reg_count = (f > fsba_pkg::MAX_SLOTS) ? fsba_pkg::MAX_SLOTS : f;
                rebuild_pool();
            end
            fsba_pkg::CFG_SLOT_SIZE: begin
                f = 32'(v[fsba_pkg::SIZE_W-1:0]);
                reg_size = (f > fsba_pkg::SIZE_LIMIT) ? fsba_pkg::SIZE_LIMIT : f;
            end
            fsba_pkg::CFG_BUFFER_TAG: begin
                reg_tag = v;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_slot_result compute_slot_result(
                                         input logic [fsba_pkg::OP_W-1:0] op,
                                         input logic [fsba_pkg::IDX_W-1:0] idx);
        t_slot_result r;
        int unsigned  pos;
        int unsigned  s;
        bit           ready;
        ready     = (reg_count != 0) && (reg_size != 0);
        r         = '0;
        r.granted = idx;
        if (!ready) begin
            r.status = fsba_pkg::STS_NOT_READY;
            if (op == fsba_pkg::OP_ALLOC) r.granted = '0;
        end else if (op == fsba_pkg::OP_ALLOC) begin
            r.granted = '0;
            if (pool_depth == 0) begin
                r.status = fsba_pkg::STS_NO_FREE;
            end else begin
                pos = reg_count - pool_depth;
                s   = (pos < fsba_pkg::MAX_SLOTS) ? pool_stack[pos] : 0;
                if (s >= reg_count || s >= fsba_pkg::MAX_SLOTS || pool_busy[s]) begin
                    r.status = fsba_pkg::STS_NO_FREE;
                end else begin
                    pool_depth--;
                    pool_busy[s] = 1'b1;
                    pool_held++;
                    r.status  = fsba_pkg::STS_OK;
                    r.granted = s[fsba_pkg::IDX_W-1:0];
                end
            end
        end else if (32'(idx) >= reg_count) begin
            r.status = fsba_pkg::STS_BAD_INDEX;
        end else if (op == fsba_pkg::OP_FREE) begin
            if (!pool_busy[idx] || pool_depth >= reg_count || pool_held == 0) begin
                r.status = fsba_pkg::STS_WRONG_STATE;
            end else begin
                pool_busy[idx] = 1'b0;
                pool_depth++;
                pool_stack[reg_count - pool_depth] = 32'(idx);
                pool_held--;
                r.status = fsba_pkg::STS_OK;
            end
        end else if (op == fsba_pkg::OP_DESC) begin
            if (!pool_busy[idx]) begin
                r.status = fsba_pkg::STS_WRONG_STATE;
            end else begin
                r.status = fsba_pkg::STS_OK;
                r.offset = fsba_pkg::OFS_W'(32'(idx) * reg_size);
                r.length = fsba_pkg::SIZE_W'(reg_size);
                r.tag    = reg_tag;
            end
        end else begin
            r.status = fsba_pkg::STS_OK;
            r.alloc  = pool_busy[idx];
        end
        if (ready && pool_held <= reg_count)
            r.free_cnt = fsba_pkg::CNT_W'(reg_count - pool_held);
        return r;
    endfunction

    function automatic t_slot_result mk_result(input logic [fsba_pkg::STATUS_W-1:0] status,
                                               input logic [fsba_pkg::IDX_W-1:0] granted,
                                               input logic [fsba_pkg::OFS_W-1:0] offset,
                                               input logic [fsba_pkg::SIZE_W-1:0] length,
                                               input logic [fsba_pkg::TAG_W-1:0] tag,
                                               input logic alloc,
                                               input logic [fsba_pkg::CNT_W-1:0] free_cnt);
        t_slot_result r;
        r.status   = status;
        r.granted  = granted;
        r.offset   = offset;
        r.length   = length;
        r.tag      = tag;
        r.alloc    = alloc;
        r.free_cnt = free_cnt;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [fsba_pkg::CFG_IDX_W-1:0] ri,
                                         input logic [fsba_pkg::CFG_W-1:0] v);
        t_dir_row d;
        d         = '0;
        d.is_cfg  = 1'b1;
        d.reg_idx = ri;
        d.reg_val = v;
        return d;
    endfunction

    function automatic t_dir_row req_row(input logic [fsba_pkg::OP_W-1:0] op,
                                         input logic [fsba_pkg::IDX_W-1:0] idx);
        t_dir_row d;
        d     = '0;
        d.op  = op;
        d.idx = idx;
        return d;
    endfunction

    function automatic t_dir_row chk_row(input logic [fsba_pkg::OP_W-1:0] op,
                                         input logic [fsba_pkg::IDX_W-1:0] idx,
                                         input t_slot_result want);
        t_dir_row d;
        d       = req_row(op, idx);
        d.typed = 1'b1;
        d.want  = want;
        return d;
    endfunction

    function automatic string fmt_res(input t_slot_result r);
        return $sformatf("sts=%0d slot=%0d ofs=%0h len=%0h tag=%08h alloc=%0b free=%0d",
                         r.status, r.granted, r.offset, r.length, r.tag, r.alloc,
                         r.free_cnt);
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [fsba_pkg::CFG_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 15) return 32'd1;
        if (roll < 25) return fsba_pkg::SIZE_LIMIT;
        if (roll < 32) return $urandom();
        return $urandom_range(1, 1 << $urandom_range(0, 20));
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // request side: random gap, then hold the transfer until it is taken
    task automatic send_request(input logic [fsba_pkg::OP_W-1:0] op,
                                input logic [fsba_pkg::IDX_W-1:0] idx,
                                input bit typed, input t_slot_result typed_res);
        int           gap;
        t_slot_result want;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_slot_index <= idx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = compute_slot_result(op, idx);
        if (typed) want = typed_res;
        slot_results_due.push_back(want);
        requests_sent++;
        if (want.status < 5) status_seen[want.status]++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (slot_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fsba_pkg::CFG_IDX_W-1:0] ri,
                             input logic [fsba_pkg::CFG_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg_write(ri, v);
        reg_writes++;
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        int roll;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen_res.status   = o_status;
            seen_res.granted  = o_granted_slot;
            seen_res.offset   = o_byte_offset;
            seen_res.length   = o_byte_length;
            seen_res.tag      = o_tag_out;
            seen_res.alloc    = o_is_allocated;
            seen_res.free_cnt = o_free_slots;
            results_checked++;
            if (slot_results_due.size() == 0) begin
                flag_error($sformatf("result with none due: %s", fmt_res(seen_res)));
            end else begin
                due_res = slot_results_due.pop_front();
                if (seen_res !== due_res)
                    flag_error($sformatf("result %0d: expected %s, got %s",
                                         results_checked, fmt_res(due_res),
                                         fmt_res(seen_res)));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                i_out_stall <= 1'b0;
                stall_left  = $urandom_range(0, 6);
            end else if (roll < 93) begin
                i_out_stall <= 1'b1;
                stall_left  = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  = $urandom_range(15, 50);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still due",
                     idle_cycles, slot_results_due.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                             roll;
        int                             hold_at;
        int                             tries;
        logic [fsba_pkg::CFG_W-1:0]     new_count;
        logic [fsba_pkg::CFG_W-1:0]     new_tag;
        logic [fsba_pkg::OP_W-1:0]      op;
        logic [fsba_pkg::IDX_W-1:0]     idx;

        reg_count = 0;
        reg_size  = 1;
        reg_tag   = 0;
        rebuild_pool();

        directed.push_back(chk_row(fsba_pkg::OP_ALLOC, 10'd1023,
                                   mk_result(fsba_pkg::STS_NOT_READY, '0, '0, '0, '0,
                                             1'b0, '0)));
        directed.push_back(chk_row(fsba_pkg::OP_QUERY, 10'd1023,
                                   mk_result(fsba_pkg::STS_NOT_READY, 10'd1023, '0, '0, '0,
                                             1'b0, '0)));
        directed.push_back(cfg_row(fsba_pkg::CFG_SLOT_SIZE, 32'd0));
        directed.push_back(cfg_row(fsba_pkg::CFG_SLOT_COUNT, 32'd4));
        directed.push_back(chk_row(fsba_pkg::OP_ALLOC, 10'd5,
                                   mk_result(fsba_pkg::STS_NOT_READY, '0, '0, '0, '0,
                                             1'b0, '0)));
        directed.push_back(cfg_row(fsba_pkg::CFG_SLOT_SIZE, 32'h001F_FFFF));
        directed.push_back(cfg_row(fsba_pkg::CFG_BUFFER_TAG, 32'hFFFF_FFFF));
        directed.push_back(chk_row(fsba_pkg::OP_ALLOC, 10'd1023,
                                   mk_result(fsba_pkg::STS_OK, 10'd0, '0, '0, '0,
                                             1'b0, 11'd3)));
        directed.push_back(chk_row(fsba_pkg::OP_ALLOC, 10'd0,
                                   mk_result(fsba_pkg::STS_OK, 10'd1, '0, '0, '0,
                                             1'b0, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_DESC, 10'd1,
                                   mk_result(fsba_pkg::STS_OK, 10'd1, 30'h10_0000,
                                             21'h10_0000, 32'hFFFF_FFFF, 1'b0, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_DESC, 10'd3,
                                   mk_result(fsba_pkg::STS_WRONG_STATE, 10'd3, '0, '0, '0,
                                             1'b0, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_FREE, 10'd3,
                                   mk_result(fsba_pkg::STS_WRONG_STATE, 10'd3, '0, '0, '0,
                                             1'b0, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_QUERY, 10'd0,
                                   mk_result(fsba_pkg::STS_OK, 10'd0, '0, '0, '0,
                                             1'b1, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_QUERY, 10'd4,
                                   mk_result(fsba_pkg::STS_BAD_INDEX, 10'd4, '0, '0, '0,
                                             1'b0, 11'd2)));
        directed.push_back(chk_row(fsba_pkg::OP_FREE, 10'd1,
                                   mk_result(fsba_pkg::STS_OK, 10'd1, '0, '0, '0,
                                             1'b0, 11'd3)));
        directed.push_back(req_row(fsba_pkg::OP_ALLOC, 10'd0));
        directed.push_back(req_row(fsba_pkg::OP_ALLOC, 10'd0));
        directed.push_back(req_row(fsba_pkg::OP_ALLOC, 10'd0));
        directed.push_back(chk_row(fsba_pkg::OP_ALLOC, 10'd0,
                                   mk_result(fsba_pkg::STS_NO_FREE, '0, '0, '0, '0,
                                             1'b0, '0)));
        directed.push_back(chk_row(fsba_pkg::OP_DESC, 10'd1023,
                                   mk_result(fsba_pkg::STS_BAD_INDEX, 10'd1023, '0, '0, '0,
                                             1'b0, '0)));
        directed.push_back(cfg_row(fsba_pkg::CFG_SLOT_COUNT, 32'hFFFF_FFFF));
        directed.push_back(chk_row(fsba_pkg::OP_FREE, 10'd1023,
                                   mk_result(fsba_pkg::STS_WRONG_STATE, 10'd1023, '0, '0,
                                             '0, 1'b0, 11'd1024)));
        directed.push_back(req_row(fsba_pkg::OP_ALLOC, 10'd0));
        directed.push_back(req_row(fsba_pkg::OP_DESC, 10'd0));
        directed.push_back(cfg_row(fsba_pkg::CFG_SLOT_COUNT, 32'd0));
        directed.push_back(chk_row(fsba_pkg::OP_FREE, 10'd512,
                                   mk_result(fsba_pkg::STS_NOT_READY, 10'd512, '0, '0, '0,
                                             1'b0, '0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg)
                write_reg(directed[k].reg_idx, directed[k].reg_val);
            else
                send_request(directed[k].op, directed[k].idx, directed[k].typed,
                             directed[k].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (phase == 0 || $urandom_range(0, 4) != 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 40)      new_count = $urandom_range(1, 8);
                else if (roll < 65) new_count = $urandom_range(9, 32);
                else if (roll < 80) new_count = $urandom_range(33, 300);
                else if (roll < 88) new_count = fsba_pkg::MAX_SLOTS;
                else if (roll < 95) new_count = $urandom();
                else                new_count = '0;
                write_reg(fsba_pkg::CFG_SLOT_COUNT, new_count);
            end
            write_reg(fsba_pkg::CFG_SLOT_SIZE, pick_size());
            roll = $urandom_range(0, 99);
            if (roll < 10)      new_tag = '0;
            else if (roll < 20) new_tag = '1;
            else                new_tag = $urandom();
            write_reg(fsba_pkg::CFG_BUFFER_TAG, new_tag);

            hold_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == hold_at) begin
                    // size change mid-phase must not rebuild the pool
                    if ($urandom_range(0, 1) != 0)
                        write_reg(fsba_pkg::CFG_SLOT_SIZE, pick_size());
                    else
                        wait_idle();
                end
                roll = $urandom_range(0, 99);
                idx  = fsba_pkg::IDX_W'($urandom_range(0, fsba_pkg::MAX_SLOTS - 1));
                if (reg_count != 0 && $urandom_range(0, 9) != 0)
                    idx = fsba_pkg::IDX_W'($urandom_range(0, reg_count - 1));
                if (roll < 40) begin
                    op = fsba_pkg::OP_ALLOC;
                end else if (roll < 78) begin
                    op = fsba_pkg::OP_FREE;
                    // mostly return a slot that is really held
                    if (roll < 70 && reg_count != 0)
                        for (tries = 0; tries < 8 && !pool_busy[idx]; tries++)
                            idx = fsba_pkg::IDX_W'($urandom_range(0, reg_count - 1));
                end else if (roll < 89) begin
                    op = fsba_pkg::OP_DESC;
                end else begin
                    op = fsba_pkg::OP_QUERY;
                end
                send_request(op, idx, 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (slot_results_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests and %0d checked results over %0d register writes",
                 requests_sent, results_checked, reg_writes);
        $display("status mix: ok %0d, not ready %0d, no free slot %0d, bad index %0d, %s %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "wrong state", status_seen[4]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
